### src/ttsm_pkg.sv
// Shared types and constants for the touch-to-screen mapper.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ttsm_pkg;

  // Input commands.
  localparam logic [2:0] CMD_X    = 3'd0;
  localparam logic [2:0] CMD_Y    = 3'd1;
  localparam logic [2:0] CMD_DOWN = 3'd2;
  localparam logic [2:0] CMD_UP   = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_X       = 2'd0;
  localparam logic [1:0] KIND_Y       = 2'd1;
  localparam logic [1:0] KIND_PRESS   = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_AREA_ENABLE  = 3'd0;
  localparam logic [2:0] REG_REGION_MIN_X = 3'd1;
  localparam logic [2:0] REG_REGION_MIN_Y = 3'd2;
  localparam logic [2:0] REG_REGION_MAX_X = 3'd3;
  localparam logic [2:0] REG_REGION_MAX_Y = 3'd4;
  localparam logic [2:0] REG_PAD_RANGE_X  = 3'd5;
  localparam logic [2:0] REG_PAD_RANGE_Y  = 3'd6;
  localparam logic [2:0] REG_TAP_LIMIT    = 3'd7;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SCR_W   = 12;
  localparam int unsigned TAP_W   = 10;
  localparam int unsigned NUM_W   = COORD_W + SCR_W;

  localparam logic [TAP_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [2:0]         command;
    logic [COORD_W-1:0] coord_value;
  } in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [SCR_W-1:0] screen_value;
    logic             last;
  } out_t;

  typedef struct packed {
    logic               area_enable;
    logic [COORD_W-1:0] region_min_x;
    logic [COORD_W-1:0] region_min_y;
    logic [COORD_W-1:0] region_max_x;
    logic [COORD_W-1:0] region_max_y;
    logic [COORD_W-1:0] pad_range_x;
    logic [COORD_W-1:0] pad_range_y;
    logic [TAP_W-1:0]   tap_limit_ms;
  } cfg_t;

  // Work handed from the front to the back. When direct is set, value is the
  // finished screen value; otherwise value is the saturation limit and the
  // back divides numer by den. A press job also makes the back emit a release.
  typedef struct packed {
    logic [1:0]         kind;
    logic               direct;
    logic [SCR_W-1:0]   value;
    logic [NUM_W-1:0]   numer;
    logic [COORD_W-1:0] den;
  } job_t;

endpackage
`default_nettype wire

### src/ttsm_front.sv
// Front end: accepts input events, keeps the tap timer and prepares jobs.
// Depends on ttsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttsm_front import ttsm_pkg::*; #(
  parameter int unsigned SCREEN_W = 1920,
  parameter int unsigned SCREEN_H = 1080
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_push,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_job
);

  localparam logic [SCR_W-1:0] SCR_X = SCR_W'(SCREEN_W);
  localparam logic [SCR_W-1:0] SCR_Y = SCR_W'(SCREEN_H);

  logic             tap_active_r, tap_active_nxt;
  logic [TAP_W-1:0] tap_elapsed_r, tap_elapsed_nxt;

  logic               accept;
  logic               is_y;
  logic [COORD_W-1:0] lo, hi, range, raw, clamped, span, offs;
  logic [SCR_W-1:0]   scr;

  assign accept = in_push && !q_full;
  assign is_y   = (in_data.command == CMD_Y);
  assign raw    = in_data.coord_value;
  assign lo     = is_y ? cfg.region_min_y : cfg.region_min_x;
  assign hi     = is_y ? cfg.region_max_y : cfg.region_max_x;
  assign range  = is_y ? cfg.pad_range_y  : cfg.pad_range_x;
  assign scr    = is_y ? SCR_Y : SCR_X;

  always_comb begin
    if (raw < lo) begin
      clamped = lo;
    end else if (raw > hi) begin
      clamped = hi;
    end else begin
      clamped = raw;
    end
    span = hi - lo;
    offs = cfg.area_enable ? (clamped - lo) : raw;
  end

  always_comb begin
    tap_active_nxt  = tap_active_r;
    tap_elapsed_nxt = tap_elapsed_r;
    q_push          = 1'b0;
    q_job.kind      = is_y ? KIND_Y : KIND_X;
    q_job.direct    = 1'b0;
    q_job.value     = scr;
    q_job.numer     = NUM_W'(offs) * NUM_W'(scr);
    q_job.den       = cfg.area_enable ? span : range;
    if (cfg.area_enable ? (hi <= lo) : (range == '0)) begin
      q_job.direct = 1'b1;
    end
    if (accept) begin
      unique case (in_data.command)
        CMD_X, CMD_Y: begin
          q_push = 1'b1;
        end
        CMD_DOWN: begin
          tap_active_nxt  = 1'b1;
          tap_elapsed_nxt = '0;
        end
        CMD_UP: begin
          if (tap_active_r) begin
            tap_active_nxt = 1'b0;
            if (tap_elapsed_r < cfg.tap_limit_ms) begin
              q_push       = 1'b1;
              q_job.kind   = KIND_PRESS;
              q_job.direct = 1'b1;
              q_job.value  = '0;
            end
          end
        end
        CMD_TICK: begin
          if (tap_active_r && tap_elapsed_r != ELAPSED_MAX) begin
            tap_elapsed_nxt = tap_elapsed_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_active_r  <= 1'b0;
      tap_elapsed_r <= '0;
    end else begin
      tap_active_r  <= tap_active_nxt;
      tap_elapsed_r <= tap_elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

### src/ttsm_queue.sv
// Short job queue between the front end and the back end.
// Depends on ttsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttsm_queue import ttsm_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

### src/ttsm_back.sv
// Back end: serial restoring divider, saturation and the result register.
// Depends on ttsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttsm_back import ttsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire job_t q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(NUM_W - 1);

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] den_r, den_nxt;
  logic [SCR_W-1:0]   lim_r, lim_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [SCR_W-1:0]   res_r, res_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [COORD_W:0]   rem_sh;
  logic               ge;
  logic               out_free;

  assign rem_sh    = {rem_r, quo_r[NUM_W-1]};
  assign ge        = (rem_sh >= {1'b0, den_r});
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    lim_nxt       = lim_r;
    kind_nxt      = kind_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          kind_nxt = q_head.kind;
          res_nxt  = q_head.value;
          lim_nxt  = q_head.value;
          // A finished value stands in for the quotient so it passes the clip as is.
          quo_nxt  = q_head.direct ? NUM_W'(q_head.value) : q_head.numer;
          den_nxt  = q_head.den;
          rem_nxt  = '0;
          cnt_nxt  = CNT_START;
          state_nxt = q_head.direct ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? COORD_W'(rem_sh - {1'b0, den_r}) : rem_sh[COORD_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Quotient is final here; clip it to the screen size of its axis.
        if (kind_r == KIND_X || kind_r == KIND_Y) begin
          if (quo_r > NUM_W'(lim_r)) begin
            res_nxt = lim_r;
          end else begin
            res_nxt = quo_r[SCR_W-1:0];
          end
        end
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.result_kind  = kind_r;
          out_nxt.screen_value = (kind_r == KIND_PRESS || kind_r == KIND_RELEASE)
                                 ? '0 : res_nxt;
          out_nxt.last         = (kind_r != KIND_PRESS);
          if (kind_r == KIND_PRESS) begin
            kind_nxt = KIND_RELEASE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    lim_r  <= lim_nxt;
    kind_r <= kind_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

### src/touch_to_screen_mapper_unit.sv
// Top level of the touch-to-screen mapper: configuration registers, front end,
// job queue and back end. Depends on ttsm_pkg, ttsm_front, ttsm_queue, ttsm_back.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_push / in_full  | in_data  (command, coord_value)
//   out_    | output    | out_empty / out_pop| out_data (result_kind,
//           |           |                    |           screen_value, last)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A coordinate event passes the queue, 28 iterations of the one-bit-per-cycle
// restoring divider in the back end, and a step that saturates and loads the
// result register; a busy back end or an unpopped result can hold it up.
// Touch and tick events finish in the front end in the cycle they are
// accepted; a click adds two results, one per cycle of a free output.
// Reset is synchronous and active low; it restores the register defaults,
// stops the tap timer and empties the queue and the result register.
// The front end keeps taking events until the queue fills, so a stalled
// result consumer only backs up the input once the queue and divider are busy.
`timescale 1ns / 1ps
`default_nettype none
module touch_to_screen_mapper_unit import ttsm_pkg::*; #(
  parameter int unsigned SCREEN_W    = 1920,
  parameter int unsigned SCREEN_H    = 1080,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Event input.
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire in_t                 in_data,
  // Results.
  output logic                     out_empty,
  input  wire logic                out_pop,
  output out_t                     out_data,
  // Configuration writes.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [COORD_W-1:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  // Registers are always writable; a transfer completes whenever valid is high.
  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_AREA_ENABLE:  cfg_nxt.area_enable  = cfg_data[0];
        REG_REGION_MIN_X: cfg_nxt.region_min_x = cfg_data;
        REG_REGION_MIN_Y: cfg_nxt.region_min_y = cfg_data;
        REG_REGION_MAX_X: cfg_nxt.region_max_x = cfg_data;
        REG_REGION_MAX_Y: cfg_nxt.region_max_y = cfg_data;
        REG_PAD_RANGE_X:  cfg_nxt.pad_range_x  = cfg_data;
        REG_PAD_RANGE_Y:  cfg_nxt.pad_range_y  = cfg_data;
        REG_TAP_LIMIT:    cfg_nxt.tap_limit_ms = cfg_data[TAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_enable  <= 1'b0;
      cfg_r.region_min_x <= '0;
      cfg_r.region_min_y <= '0;
      cfg_r.region_max_x <= COORD_W'(4095);
      cfg_r.region_max_y <= COORD_W'(4095);
      cfg_r.pad_range_x  <= COORD_W'(4095);
      cfg_r.pad_range_y  <= COORD_W'(4095);
      cfg_r.tap_limit_ms <= TAP_W'(200);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: decodes events, runs the tap timer and sets up divisions.
  ttsm_front #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  // Decoupling queue between the two halves.
  ttsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: divides, saturates and presents results one at a time.
  ttsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for touch_to_screen_mapper_unit: directed and random event traffic.
// Depends on ttsm_pkg and the RTL only. A built-in predictor works out the expected results,
// and one checker process compares every result that leaves the block against them.
`timescale 1ns / 1ps
module testbench;
  import ttsm_pkg::*;

  localparam int unsigned DISP_W = 1920;
  localparam int unsigned DISP_H = 1080;
  // This margin covers the divider latency with room to spare.
  localparam int unsigned LATENCY_CYCLES = 48;
  localparam longint unsigned RUN_LIMIT_NS = 10_000_000;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  in_t              in_data = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  // Predictor state: a shadow of the registers and of the tap timer.
  cfg_t             live_cfg;
  logic             tap_on;
  logic [TAP_W-1:0] tap_ms;

  out_t        pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned pop_stall_pct  = 0;

  touch_to_screen_mapper_unit #(
    .SCREEN_W (DISP_W),
    .SCREEN_H (DISP_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Screen coordinate for one axis. In area mode the raw value is clamped to the
  // region, which is stretched over the whole screen; otherwise the pad range is
  // the full scale. Degenerate regions and a zero range give the full screen size.
  function automatic logic [SCR_W-1:0] scale_axis(logic [COORD_W-1:0] raw,
                                                  logic [COORD_W-1:0] lo,
                                                  logic [COORD_W-1:0] hi,
                                                  logic [COORD_W-1:0] span,
                                                  int unsigned scr);
    longint unsigned c;
    longint unsigned q;
    if (live_cfg.area_enable) begin
      if (hi <= lo) return SCR_W'(scr);
      c = raw;
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      q = ((c - lo) * scr) / (hi - lo);
    end else begin
      if (span == '0) return SCR_W'(scr);
      q = (longint'(raw) * scr) / span;
    end
    if (q > scr) q = scr;
    return SCR_W'(q);
  endfunction

  function automatic out_t make_result(logic [1:0] kind, logic [SCR_W-1:0] value, logic last);
    out_t r;
    r.result_kind  = kind;
    r.screen_value = value;
    r.last         = last;
    return r;
  endfunction

  // Called once per accepted event; queues whatever results it causes.
  function automatic void predict_event(in_t ev);
    case (ev.command)
      CMD_X: pending_results.push_back(make_result(KIND_X,
                 scale_axis(ev.coord_value, live_cfg.region_min_x, live_cfg.region_max_x,
                            live_cfg.pad_range_x, DISP_W), 1'b1));
      CMD_Y: pending_results.push_back(make_result(KIND_Y,
                 scale_axis(ev.coord_value, live_cfg.region_min_y, live_cfg.region_max_y,
                            live_cfg.pad_range_y, DISP_H), 1'b1));
      CMD_DOWN: begin
        tap_on = 1'b1;
        tap_ms = '0;
      end
      CMD_UP: begin
        // A release only clicks when the touch was shorter than the tap limit.
        if (tap_on) begin
          tap_on = 1'b0;
          if (tap_ms < live_cfg.tap_limit_ms) begin
            pending_results.push_back(make_result(KIND_PRESS, '0, 1'b0));
            pending_results.push_back(make_result(KIND_RELEASE, '0, 1'b1));
          end
        end
      end
      CMD_TICK: begin
        if (tap_on && tap_ms != ELAPSED_MAX) tap_ms = tap_ms + 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [COORD_W-1:0] data);
    case (idx)
      REG_AREA_ENABLE:  live_cfg.area_enable  = data[0];
      REG_REGION_MIN_X: live_cfg.region_min_x = data;
      REG_REGION_MIN_Y: live_cfg.region_min_y = data;
      REG_REGION_MAX_X: live_cfg.region_max_x = data;
      REG_REGION_MAX_Y: live_cfg.region_max_y = data;
      REG_PAD_RANGE_X:  live_cfg.pad_range_x  = data;
      REG_PAD_RANGE_Y:  live_cfg.pad_range_y  = data;
      REG_TAP_LIMIT:    live_cfg.tap_limit_ms = data[TAP_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and consumer
  // ---------------------------------------------------------------------------

  // The consumer decides at each falling edge whether to take a result.
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, screen_value %0d, last %0d",
               out_data.result_kind, out_data.screen_value, out_data.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind mismatch: expected %0d, actual %0d",
                 want.result_kind, out_data.result_kind);
          mismatch_count++;
        end
        if (out_data.screen_value !== want.screen_value) begin
          $error("screen_value mismatch: expected %0d, actual %0d",
                 want.screen_value, out_data.screen_value);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task below is entered and left at a falling clock edge.
  // ---------------------------------------------------------------------------

  function automatic in_t make_event(logic [2:0] cmd, logic [COORD_W-1:0] coord);
    in_t ev;
    ev.command     = cmd;
    ev.coord_value = coord;
    return ev;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(65535));
    endcase
  endfunction

  // Push stays high across back-to-back transfers; it only drops for idle gaps.
  task automatic send_event(in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_event(ev);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the block run dry.
  task automatic settle(int unsigned extra_cycles);
    in_push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  // Writes all eight registers. Bits above a narrow register's width carry
  // random junk so that the block is seen to ignore them.
  task automatic load_config(cfg_t c);
    logic [COORD_W-1:0] junk;
    junk = COORD_W'($urandom);
    settle(LATENCY_CYCLES);
    write_cfg(REG_AREA_ENABLE,  {junk[COORD_W-1:1], c.area_enable});
    write_cfg(REG_REGION_MIN_X, c.region_min_x);
    write_cfg(REG_REGION_MIN_Y, c.region_min_y);
    write_cfg(REG_REGION_MAX_X, c.region_max_x);
    write_cfg(REG_REGION_MAX_Y, c.region_max_y);
    write_cfg(REG_PAD_RANGE_X,  c.pad_range_x);
    write_cfg(REG_PAD_RANGE_Y,  c.pad_range_y);
    write_cfg(REG_TAP_LIMIT,    {junk[COORD_W-1:TAP_W], c.tap_limit_ms});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    pop_stall_pct = receiver_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: plain scaling by a pad range of 4095, with saturation.
  task automatic test_default_scaling();
    send_event(make_event(CMD_X, 16'd0));
    send_event(make_event(CMD_X, 16'hFFFF));
    send_event(make_event(CMD_X, 16'd4095));
    send_event(make_event(CMD_X, 16'd2048));
    send_event(make_event(CMD_Y, 16'd0));
    send_event(make_event(CMD_Y, 16'hFFFF));
    send_event(make_event(CMD_Y, 16'd4094));
  endtask

  // Area mode: clamping on both sides, regions with max at or below min, then a full-range X region.
  task automatic test_area_mapping();
    cfg_t c;
    c = live_cfg;
    c.area_enable  = 1'b1;
    c.region_min_x = 16'd1000;
    c.region_max_x = 16'd3000;
    c.region_min_y = 16'd500;
    c.region_max_y = 16'd2500;
    load_config(c);
    send_event(make_event(CMD_X, 16'd0));
    send_event(make_event(CMD_X, 16'hFFFF));
    send_event(make_event(CMD_X, 16'd2000));
    send_event(make_event(CMD_Y, 16'd0));
    send_event(make_event(CMD_Y, 16'hFFFF));
    send_event(make_event(CMD_Y, 16'd1499));
    c.region_max_x = 16'd1000;
    c.region_min_y = 16'hFFFF;
    c.region_max_y = 16'd100;
    load_config(c);
    send_event(make_event(CMD_X, 16'd5000));
    send_event(make_event(CMD_Y, 16'd7));
    c.region_min_x = 16'd0;
    c.region_max_x = 16'hFFFF;
    load_config(c);
    send_event(make_event(CMD_X, 16'hFFFF));
  endtask

  // Pad range extremes outside area mode, zero range included.
  task automatic test_pad_range_extremes();
    cfg_t c;
    c = live_cfg;
    c.area_enable = 1'b0;
    c.pad_range_x = 16'd0;
    c.pad_range_y = 16'd1;
    load_config(c);
    send_event(make_event(CMD_X, 16'd12345));
    send_event(make_event(CMD_Y, 16'd0));
    send_event(make_event(CMD_Y, 16'd1));
    c.pad_range_x = 16'hFFFF;
    c.pad_range_y = 16'hFFFF;
    load_config(c);
    send_event(make_event(CMD_X, 16'hFFFF));
    send_event(make_event(CMD_X, 16'd32768));
    send_event(make_event(CMD_Y, 16'hFFFF));
  endtask

  // Tap detection: short and long touches, a restart by a second touch-down,
  // a stray touch-up, ticks while idle, unknown commands and a zero tap limit.
  task automatic test_tap_gestures();
    cfg_t c;
    c = live_cfg;
    c.tap_limit_ms = 10'd3;
    load_config(c);
    send_event(make_event(CMD_UP, rand_coord()));
    send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_DOWN, rand_coord()));
    send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_UP, rand_coord()));
    send_event(make_event(CMD_DOWN, rand_coord()));
    repeat (3) send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_UP, rand_coord()));
    send_event(make_event(CMD_DOWN, rand_coord()));
    repeat (2) send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_DOWN, rand_coord()));
    send_event(make_event(CMD_X, 16'd777));
    repeat (2) send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(3'd5, 16'hFFFF));
    send_event(make_event(3'd6, 16'h5A5A));
    send_event(make_event(3'd7, 16'd0));
    send_event(make_event(CMD_UP, rand_coord()));
    c.tap_limit_ms = 10'd0;
    load_config(c);
    send_event(make_event(CMD_DOWN, rand_coord()));
    send_event(make_event(CMD_UP, rand_coord()));
  endtask

  // A touch one tick shorter than a larger limit still clicks; a touch that
  // reaches the limit exactly does not.
  task automatic test_tap_limit_edge();
    cfg_t c;
    c = live_cfg;
    c.tap_limit_ms = 10'd20;
    load_config(c);
    send_event(make_event(CMD_DOWN, rand_coord()));
    repeat (19) send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_UP, rand_coord()));
    send_event(make_event(CMD_DOWN, rand_coord()));
    repeat (20) send_event(make_event(CMD_TICK, rand_coord()));
    send_event(make_event(CMD_UP, rand_coord()));
  endtask

  function automatic void pick_region(output logic [COORD_W-1:0] lo,
                                      output logic [COORD_W-1:0] hi);
    case ($urandom_range(9))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = COORD_W'($urandom_range(65535));
        hi = COORD_W'($urandom_range(lo));
      end
      default: begin
        lo = COORD_W'($urandom_range(30000));
        hi = lo + COORD_W'($urandom_range(1, 35535));
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_pad_range();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      default: return COORD_W'($urandom_range(100, 65535));
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.area_enable = 1'($urandom_range(1));
    pick_region(c.region_min_x, c.region_max_x);
    pick_region(c.region_min_y, c.region_max_y);
    c.pad_range_x = pick_pad_range();
    c.pad_range_y = pick_pad_range();
    case ($urandom_range(9))
      0:       c.tap_limit_ms = '0;
      1:       c.tap_limit_ms = '1;
      default: c.tap_limit_ms = TAP_W'($urandom_range(1, 10));
    endcase
    return c;
  endfunction

  // Mostly complete touch sessions (down, coordinates mixed with ticks, up)
  // whose length straddles the tap limit; the rest is arbitrary commands.
  task automatic run_block(int unsigned n_items, bit pause_midway);
    int unsigned sent;
    int unsigned n_ticks;
    int unsigned n_coords;
    int unsigned cap;
    sent = 0;
    while (sent < n_items) begin
      if (pause_midway && sent >= n_items / 2) begin
        settle(0);
        pause_midway = 1'b0;
      end
      if ($urandom_range(99) < 75) begin
        cap = (live_cfg.tap_limit_ms < 10) ? live_cfg.tap_limit_ms : 10;
        n_ticks  = $urandom_range(cap + 2);
        n_coords = $urandom_range(3);
        send_event(make_event(CMD_DOWN, rand_coord()));
        sent += n_ticks + n_coords + 2;
        while (n_ticks + n_coords > 0) begin
          if (n_coords > 0 && $urandom_range(n_ticks + n_coords - 1) < n_coords) begin
            n_coords--;
            send_event(make_event($urandom_range(1) ? CMD_Y : CMD_X, rand_coord()));
          end else begin
            n_ticks--;
            send_event(make_event(CMD_TICK, rand_coord()));
          end
        end
        send_event(make_event(CMD_UP, rand_coord()));
      end else begin
        send_event(make_event(3'($urandom_range(7)), rand_coord()));
        sent++;
      end
    end
  endtask

  // Three configurations per idling pattern; the first block of each also
  // pauses the sender until every outstanding result has been taken.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned sender_pct[4]   = '{0, 82, 0, 9};
    int unsigned receiver_pct[4] = '{0, 0, 82, 9};
    for (phase = 0; phase < 4; phase++) begin
      for (int blk = 0; blk < 3; blk++) begin
        load_config(random_setting());
        set_idling(sender_pct[phase], receiver_pct[phase]);
        run_block(50, blk == 0);
      end
    end
  endtask

  initial begin : main_sequence
    live_cfg = '{area_enable: 1'b0, region_min_x: 16'd0, region_min_y: 16'd0,
                 region_max_x: 16'd4095, region_max_y: 16'd4095,
                 pad_range_x: 16'd4095, pad_range_y: 16'd4095, tap_limit_ms: 10'd200};
    tap_on = 1'b0;
    tap_ms = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_scaling();
    test_area_mapping();
    test_pad_range_extremes();
    test_tap_gestures();
    test_tap_limit_edge();
    test_random_traffic();

    settle(LATENCY_CYCLES);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
